// File: design/r2fft_pkg.sv
// Shared types, constants and twiddle table for the radix-2 FFT block.
package r2fft_pkg;

    localparam int MAX_LOG_SIZE = 12;
    localparam int SAMPLE_W     = 16;
    localparam int TW_W         = 18;
    localparam int TW_FRAC      = TW_W - 2;
    localparam int STORE_W      = SAMPLE_W + MAX_LOG_SIZE + 1;
    localparam int DEPTH        = 1 << MAX_LOG_SIZE;
    localparam int QUARTER      = DEPTH >> 2;
    localparam int ADDR_W       = MAX_LOG_SIZE;
    localparam int TW_IDX_W     = MAX_LOG_SIZE - 1;
    localparam int ROM_ADDR_W   = MAX_LOG_SIZE - 1;
    localparam int LOG_W        = 4;
    localparam int CFG_DATA_W   = 4;
    localparam int CALC_FRAC    = 60;
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic {
        CFG_LOG_SIZE = 1'b0,
        CFG_INVERSE  = 1'b1
    } cfg_idx_t;

    // Write data source of the stores
    typedef enum logic [2:0] {
        WSEL_SAMPLE,
        WSEL_SUM,
        WSEL_PROD,
        WSEL_A,
        WSEL_B,
        WSEL_SCALE
    } wsel_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        wsel_t               wsel;
        logic [ADDR_W-1:0]   raddr;
        logic                cap_a;
        logic                cap_b;
        logic                calc_sum;
        logic                calc_mul;
        logic                out_load;
        logic                out_clear;
        logic [TW_IDX_W-1:0] tw_m;
        logic                inverse;
        logic [LOG_W-1:0]    shift;
    } cmd_t;

    typedef logic signed [TW_W-1:0] cos_rom_t [0:QUARTER];

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[CALC_FRAC+63:CALC_FRAC];
    endfunction

    function automatic logic signed [TW_W-1:0] to_twiddle(input logic [63:0] v);
        logic [63:0] r;
        r = (v + (64'd1 << (CALC_FRAC - TW_FRAC - 1))) >> (CALC_FRAC - TW_FRAC);
        return r[TW_W-1:0];
    endfunction

    // Quarter-wave cosine table, Q2.16, built by a thirteen-term series at elaboration
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t    rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] st;
        logic [63:0] ss;
        logic [63:0] ct;
        logic [63:0] cs;
        for (int j = 0; j <= (DEPTH >> 3); j++)
        begin
            x  = (TWO_PI_Q60 >> MAX_LOG_SIZE) * 64'(j);
            x2 = mul_q60(x, x);
            st = x;
            ss = x;
            ct = 64'd1 << CALC_FRAC;
            cs = ct;
            st = mul_q60(st, x2) / 64'd6;   ct = mul_q60(ct, x2) / 64'd2;   ss -= st; cs -= ct;
            st = mul_q60(st, x2) / 64'd20;  ct = mul_q60(ct, x2) / 64'd12;  ss += st; cs += ct;
            st = mul_q60(st, x2) / 64'd42;  ct = mul_q60(ct, x2) / 64'd30;  ss -= st; cs -= ct;
            st = mul_q60(st, x2) / 64'd72;  ct = mul_q60(ct, x2) / 64'd56;  ss += st; cs += ct;
            st = mul_q60(st, x2) / 64'd110; ct = mul_q60(ct, x2) / 64'd90;  ss -= st; cs -= ct;
            st = mul_q60(st, x2) / 64'd156; ct = mul_q60(ct, x2) / 64'd132; ss += st; cs += ct;
            st = mul_q60(st, x2) / 64'd210; ct = mul_q60(ct, x2) / 64'd182; ss -= st; cs -= ct;
            st = mul_q60(st, x2) / 64'd272; ct = mul_q60(ct, x2) / 64'd240; ss += st; cs += ct;
            st = mul_q60(st, x2) / 64'd342; ct = mul_q60(ct, x2) / 64'd306; ss -= st; cs -= ct;
            st = mul_q60(st, x2) / 64'd420; ct = mul_q60(ct, x2) / 64'd380; ss += st; cs += ct;
            st = mul_q60(st, x2) / 64'd506; ct = mul_q60(ct, x2) / 64'd462; ss -= st; cs -= ct;
            st = mul_q60(st, x2) / 64'd600; ct = mul_q60(ct, x2) / 64'd552; ss += st; cs += ct;
            rom[j]           = to_twiddle(cs);
            rom[QUARTER - j] = to_twiddle(ss);
        end
        return rom;
    endfunction

endpackage

// File: design/r2fft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module r2fft_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/r2fft_dp.sv
// Datapath: sample stores, twiddle lookup, butterfly, bit-reverse swap and scaling.
module r2fft_dp (
    input  logic                                clk,
    input  r2fft_pkg::cmd_t                     cmd,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0] re_in,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0] im_in,
    output logic signed [r2fft_pkg::STORE_W-1:0]  re_out,
    output logic signed [r2fft_pkg::STORE_W-1:0]  im_out
);

    localparam int SW  = r2fft_pkg::STORE_W;
    localparam int TW  = r2fft_pkg::TW_W;
    localparam int DW  = SW + 1;
    localparam int PW  = DW + TW;
    localparam int QW  = PW + 1;
    localparam int RW  = QW - r2fft_pkg::TW_FRAC;
    localparam int AW  = r2fft_pkg::ROM_ADDR_W;
    localparam r2fft_pkg::cos_rom_t COS_ROM = r2fft_pkg::build_cos_rom();
    localparam logic [AW-1:0] QTR = AW'(r2fft_pkg::QUARTER);

    function automatic logic signed [SW-1:0] sat(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] hi;
        logic signed [RW-1:0] lo;
        hi = RW'((64'sd1 <<< (SW - 1)) - 64'sd1);
        lo = -hi - RW'(1);
        if (v > hi)
        begin
            return hi[SW-1:0];
        end
        else if (v < lo)
        begin
            return lo[SW-1:0];
        end
        return v[SW-1:0];
    endfunction

    logic signed [SW-1:0] rd_re, rd_im;
    logic signed [SW-1:0] a_re_reg, a_im_reg, b_re_reg, b_im_reg;
    logic signed [SW-1:0] s_re_reg, s_im_reg;
    logic signed [DW-1:0] d_re_reg, d_im_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;
    logic signed [TW-1:0] c1_reg, c2_reg;
    logic                 s1_reg;
    logic signed [SW-1:0] re_out_reg, im_out_reg;

    logic [AW-1:0]        rom_a1, rom_a2;
    logic                 rom_s1;
    logic signed [TW-1:0] w_re, w_im;
    logic signed [DW-1:0] sum_re, sum_im;
    logic signed [QW-1:0] q_re, q_im;
    logic signed [SW-1:0] prod_re, prod_im;
    logic signed [DW-1:0] half_lsb;
    logic signed [DW-1:0] sc_re, sc_im;
    logic signed [SW-1:0] scale_re, scale_im;
    logic signed [SW-1:0] wd_re, wd_im;

    // Twiddle addresses: first half-turn folded onto the quarter-wave table
    always_comb
    begin
        if (cmd.tw_m <= QTR)
        begin
            rom_a1 = cmd.tw_m[AW-1:0];
            rom_a2 = QTR - cmd.tw_m[AW-1:0];
            rom_s1 = 1'b0;
        end
        else
        begin
            rom_a1 = QTR - {1'b0, cmd.tw_m[AW-2:0]};
            rom_a2 = {1'b0, cmd.tw_m[AW-2:0]};
            rom_s1 = 1'b1;
        end
    end

    assign w_re = s1_reg ? -c1_reg : c1_reg;
    assign w_im = cmd.inverse ? c2_reg : -c2_reg;

    assign sum_re = DW'(a_re_reg) + DW'(b_re_reg);
    assign sum_im = DW'(a_im_reg) + DW'(b_im_reg);

    assign q_re = QW'(p_rr_reg) - QW'(p_ii_reg) + QW'(64'sd1 <<< (r2fft_pkg::TW_FRAC - 1));
    assign q_im = QW'(p_ir_reg) + QW'(p_ri_reg) + QW'(64'sd1 <<< (r2fft_pkg::TW_FRAC - 1));
    assign prod_re = sat(RW'(q_re >>> r2fft_pkg::TW_FRAC));
    assign prod_im = sat(RW'(q_im >>> r2fft_pkg::TW_FRAC));

    // Inverse 1/N: rounding shift by log size
    assign half_lsb = DW'(1) <<< (cmd.shift - r2fft_pkg::LOG_W'(1));
    assign sc_re    = (DW'(a_re_reg) + half_lsb) >>> cmd.shift;
    assign sc_im    = (DW'(a_im_reg) + half_lsb) >>> cmd.shift;
    assign scale_re = sat(RW'(sc_re));
    assign scale_im = sat(RW'(sc_im));

    always_comb
    begin
        case (cmd.wsel)
            r2fft_pkg::WSEL_SAMPLE:
            begin
                wd_re = SW'(re_in);
                wd_im = SW'(im_in);
            end
            r2fft_pkg::WSEL_SUM:
            begin
                wd_re = s_re_reg;
                wd_im = s_im_reg;
            end
            r2fft_pkg::WSEL_PROD:
            begin
                wd_re = prod_re;
                wd_im = prod_im;
            end
            r2fft_pkg::WSEL_A:
            begin
                wd_re = a_re_reg;
                wd_im = a_im_reg;
            end
            r2fft_pkg::WSEL_B:
            begin
                wd_re = b_re_reg;
                wd_im = b_im_reg;
            end
            r2fft_pkg::WSEL_SCALE:
            begin
                wd_re = scale_re;
                wd_im = scale_im;
            end
            default:
            begin
                wd_re = SW'(re_in);
                wd_im = SW'(im_in);
            end
        endcase
    end

    r2fft_ram #(.WIDTH(SW), .DEPTH(r2fft_pkg::DEPTH)) u_ram_re (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (cmd.waddr),
        .wdata (wd_re),
        .raddr (cmd.raddr),
        .rdata (rd_re)
    );

    r2fft_ram #(.WIDTH(SW), .DEPTH(r2fft_pkg::DEPTH)) u_ram_im (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (cmd.waddr),
        .wdata (wd_im),
        .raddr (cmd.raddr),
        .rdata (rd_im)
    );

    always_ff @(posedge clk)
    begin
        c1_reg <= COS_ROM[rom_a1];
        c2_reg <= COS_ROM[rom_a2];
        s1_reg <= rom_s1;
        if (cmd.cap_a)
        begin
            a_re_reg <= rd_re;
            a_im_reg <= rd_im;
        end
        if (cmd.cap_b)
        begin
            b_re_reg <= rd_re;
            b_im_reg <= rd_im;
        end
        if (cmd.calc_sum)
        begin
            s_re_reg <= sat(RW'(sum_re));
            s_im_reg <= sat(RW'(sum_im));
            d_re_reg <= DW'(a_re_reg) - DW'(b_re_reg);
            d_im_reg <= DW'(a_im_reg) - DW'(b_im_reg);
        end
        if (cmd.calc_mul)
        begin
            p_rr_reg <= d_re_reg * w_re;
            p_ii_reg <= d_im_reg * w_im;
            p_ir_reg <= d_im_reg * w_re;
            p_ri_reg <= d_re_reg * w_im;
        end
        if (cmd.out_load)
        begin
            re_out_reg <= rd_re;
            im_out_reg <= rd_im;
        end
        else if (cmd.out_clear)
        begin
            re_out_reg <= '0;
            im_out_reg <= '0;
        end
    end

    assign re_out = re_out_reg;
    assign im_out = im_out_reg;

endmodule

// File: design/r2fft_ctrl.sv
// Controller: handshakes, configuration registers and the run sequencer.
module r2fft_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          op,
    input  logic [r2fft_pkg::ADDR_W-1:0]        index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [r2fft_pkg::CFG_DATA_W-1:0]    cfg_data,
    output r2fft_pkg::cmd_t                     cmd
);

    localparam int AW = r2fft_pkg::ADDR_W;
    localparam int NW = AW + 1;
    localparam int JW = r2fft_pkg::TW_IDX_W;
    localparam int LW = r2fft_pkg::LOG_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD_WAIT,
        ST_BF_RA, ST_BF_RB, ST_BF_CAPB, ST_BF_SUM, ST_BF_MUL, ST_BF_WB,
        ST_SW_CHK, ST_SW_RA, ST_SW_RB, ST_SW_CAPB, ST_SW_WA, ST_SW_WB,
        ST_SC_RD, ST_SC_CAP, ST_SC_WR, ST_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [LW-1:0]   log_size_reg, log_size_next;
    logic            inverse_reg, inverse_next;
    logic [AW-1:0]   i_reg, i_next;
    logic [JW-1:0]   j_reg, j_next;
    logic [AW-1:0]   half_reg, half_next;
    logic [LW-1:0]   tw_sh_reg, tw_sh_next;
    logic            out_valid_reg, out_valid_next;
    logic            status_reg, status_next;

    logic [LW-1:0]   eff_log;
    logic [NW-1:0]   n_size;
    logic [NW-1:0]   i_step;
    logic [AW-1:0]   k_addr;
    logic [AW-1:0]   j_inc;
    logic [AW-1:0]   rev_full, rev_i;
    logic            i_last;
    logic            idx_ok;
    logic            in_fire;

    always_comb
    begin
        if (log_size_reg < LW'(2))
        begin
            eff_log = LW'(2);
        end
        else if (log_size_reg > LW'(r2fft_pkg::MAX_LOG_SIZE))
        begin
            eff_log = LW'(r2fft_pkg::MAX_LOG_SIZE);
        end
        else
        begin
            eff_log = log_size_reg;
        end
    end

    always_comb
    begin
        for (int b = 0; b < AW; b++)
        begin
            rev_full[b] = i_reg[AW-1-b];
        end
    end

    assign n_size  = NW'(1) << eff_log;
    assign i_step  = {1'b0, i_reg} + {half_reg, 1'b0};
    assign k_addr  = i_reg + half_reg;
    assign j_inc   = AW'(j_reg) + AW'(1);
    assign rev_i   = rev_full >> (LW'(AW) - eff_log);
    assign i_last  = ({1'b0, i_reg} == (n_size - NW'(1)));
    assign idx_ok  = ({1'b0, index} < n_size);
    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        log_size_next  = log_size_reg;
        inverse_next   = inverse_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        half_next      = half_reg;
        tw_sh_next     = tw_sh_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;

        cmd           = '0;
        cmd.wsel      = r2fft_pkg::WSEL_SAMPLE;
        cmd.waddr     = i_reg;
        cmd.raddr     = i_reg;
        cmd.tw_m      = JW'(j_reg << tw_sh_reg);
        cmd.inverse   = inverse_reg;
        cmd.shift     = eff_log;

        if (cfg_valid && cfg_ready)
        begin
            unique case (r2fft_pkg::cfg_idx_t'(cfg_index))
                r2fft_pkg::CFG_LOG_SIZE: log_size_next = cfg_data[LW-1:0];
                r2fft_pkg::CFG_INVERSE:  inverse_next  = cfg_data[0];
                default:                 log_size_next = log_size_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op)
                        r2fft_pkg::OP_WRITE:
                        begin
                            cmd.we         = idx_ok;
                            cmd.waddr      = index;
                            cmd.out_clear  = 1'b1;
                            out_valid_next = 1'b1;
                            status_next    = !idx_ok;
                        end
                        r2fft_pkg::OP_READ:
                        begin
                            cmd.raddr = index;
                            if (idx_ok)
                            begin
                                state_next = ST_RD_WAIT;
                            end
                            else
                            begin
                                cmd.out_clear  = 1'b1;
                                out_valid_next = 1'b1;
                                status_next    = 1'b1;
                            end
                        end
                        r2fft_pkg::OP_RUN:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            half_next  = n_size[AW:1];
                            tw_sh_next = LW'(r2fft_pkg::MAX_LOG_SIZE) - eff_log;
                            state_next = ST_BF_RA;
                        end
                        default:
                        begin
                            cmd.out_clear  = 1'b1;
                            out_valid_next = 1'b1;
                            status_next    = 1'b0;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                status_next    = 1'b0;
                state_next     = ST_IDLE;
            end
            ST_BF_RA:
            begin
                state_next = ST_BF_RB;
            end
            ST_BF_RB:
            begin
                cmd.raddr  = k_addr;
                cmd.cap_a  = 1'b1;
                state_next = ST_BF_CAPB;
            end
            ST_BF_CAPB:
            begin
                cmd.cap_b  = 1'b1;
                state_next = ST_BF_SUM;
            end
            ST_BF_SUM:
            begin
                cmd.calc_sum = 1'b1;
                state_next   = ST_BF_MUL;
            end
            ST_BF_MUL:
            begin
                cmd.calc_mul = 1'b1;
                cmd.we       = 1'b1;
                cmd.wsel     = r2fft_pkg::WSEL_SUM;
                state_next   = ST_BF_WB;
            end
            ST_BF_WB:
            begin
                cmd.we    = 1'b1;
                cmd.waddr = k_addr;
                cmd.wsel  = r2fft_pkg::WSEL_PROD;
                if (i_step < n_size)
                begin
                    i_next     = i_step[AW-1:0];
                    state_next = ST_BF_RA;
                end
                else if (j_inc == half_reg)
                begin
                    i_next = '0;
                    j_next = '0;
                    if (half_reg == AW'(1))
                    begin
                        state_next = ST_SW_CHK;
                    end
                    else
                    begin
                        half_next  = half_reg >> 1;
                        tw_sh_next = tw_sh_reg + LW'(1);
                        state_next = ST_BF_RA;
                    end
                end
                else
                begin
                    j_next     = j_inc[JW-1:0];
                    i_next     = j_inc;
                    state_next = ST_BF_RA;
                end
            end
            ST_SW_CHK, ST_SW_WB:
            begin
                if (state_reg == ST_SW_WB)
                begin
                    cmd.we    = 1'b1;
                    cmd.waddr = rev_i;
                    cmd.wsel  = r2fft_pkg::WSEL_A;
                end
                if ((state_reg == ST_SW_CHK) && (i_reg < rev_i))
                begin
                    state_next = ST_SW_RA;
                end
                else if (i_last)
                begin
                    i_next     = '0;
                    state_next = inverse_reg ? ST_SC_RD : ST_DONE;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = ST_SW_CHK;
                end
            end
            ST_SW_RA:
            begin
                state_next = ST_SW_RB;
            end
            ST_SW_RB:
            begin
                cmd.raddr  = rev_i;
                cmd.cap_a  = 1'b1;
                state_next = ST_SW_CAPB;
            end
            ST_SW_CAPB:
            begin
                cmd.cap_b  = 1'b1;
                state_next = ST_SW_WA;
            end
            ST_SW_WA:
            begin
                cmd.we     = 1'b1;
                cmd.wsel   = r2fft_pkg::WSEL_B;
                state_next = ST_SW_WB;
            end
            ST_SC_RD:
            begin
                state_next = ST_SC_CAP;
            end
            ST_SC_CAP:
            begin
                cmd.cap_a  = 1'b1;
                state_next = ST_SC_WR;
            end
            ST_SC_WR:
            begin
                cmd.we   = 1'b1;
                cmd.wsel = r2fft_pkg::WSEL_SCALE;
                if (i_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = ST_SC_RD;
                end
            end
            ST_DONE:
            begin
                cmd.out_clear  = 1'b1;
                out_valid_next = 1'b1;
                status_next    = 1'b0;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            log_size_reg  <= LW'(r2fft_pkg::MAX_LOG_SIZE);
            inverse_reg   <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            half_reg      <= '0;
            tw_sh_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            log_size_reg  <= log_size_next;
            inverse_reg   <= inverse_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            half_reg      <= half_next;
            tw_sh_reg     <= tw_sh_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

endmodule

// File: design/radix2_complex_fft.sv
// Top level of the in-place radix-2 decimation-in-frequency complex FFT.
//
// Usage: load samples with write beats (op write, index, re_in, im_in), issue one
// run beat, then fetch bins with read beats (op read, index). Every input beat
// gives exactly one output beat: re_out/im_out carry the bin on a read and zero
// otherwise; status is 1 when index is not below N = 2^log_size (log_size is
// clamped to 2..12). Configuration (log_size, inverse) is to go in on the cfg
// channel while idle; the block itself does not enforce this. A write or an
// unused code answers from the output register; a read first passes the RAM
// read register. A run does (N/2)*log2(N) butterflies on one shared butterfly
// (the stores have one read and one write port), then the bit-reversal pass,
// then the 1/N pass in inverse mode.
// One beat is in flight at a time: in_ready drops while the block works or
// while a result waits in the output register; a stalled receiver simply
// holds the result and keeps the input side waiting.
// Reset clears the control state, sets log_size to 12 and inverse to 0; the
// sample stores are not cleared and read as garbage until written.
module radix2_complex_fft (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             op,
    input  logic [r2fft_pkg::ADDR_W-1:0]           index,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0]  re_in,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0]  im_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [r2fft_pkg::STORE_W-1:0]   re_out,
    output logic signed [r2fft_pkg::STORE_W-1:0]   im_out,
    output logic                                   status,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic                                   cfg_index,
    input  logic [r2fft_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // command bundle from sequencer to datapath
    r2fft_pkg::cmd_t cmd;

    r2fft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .index     (index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd)
    );

    // stores, twiddle table and the butterfly arithmetic
    r2fft_dp u_dp (
        .clk    (clk),
        .cmd    (cmd),
        .re_in  (re_in),
        .im_in  (im_in),
        .re_out (re_out),
        .im_out (im_out)
    );

endmodule
